// ===== sv/sitsel_pkg.sv =====
`timescale 1ns / 1ps
package sitsel_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CAP_W = 6;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;
  localparam logic [1:0] ACT_SELECT = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_MISS  = 3'd4;
  localparam logic [2:0] ST_NOPOL = 3'd5;

  localparam logic [1:0] OPT_LOOP   = 2'd0;
  localparam logic [1:0] OPT_RANDOM = 2'd1;

  localparam logic [1:0] REG_CAP0 = 2'd0;
  localparam logic [1:0] REG_CAP1 = 2'd1;
  localparam logic [1:0] REG_OPT0 = 2'd2;
  localparam logic [1:0] REG_OPT1 = 2'd3;

  typedef enum logic [1:0] {
    RD_EQ,
    RD_NEXT,
    RD_IDX
  } rd_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic     ins;
    logic     del;
    rd_mode_t mode;
  } ctrl_t;

endpackage

// ===== sv/sitsel_cell.sv =====
`timescale 1ns / 1ps
module sitsel_cell (
  input  logic               clk,
  input  sitsel_pkg::ctrl_t  ctrl,
  input  logic [31:0]        key,
  input  logic [31:0]        pay,
  input  logic               valid,
  input  logic               left_lt,
  input  logic [31:0]        left_id,
  input  logic [31:0]        left_pay,
  input  logic [31:0]        right_id,
  input  logic [31:0]        right_pay,
  output logic [31:0]        id,
  output logic [31:0]        pay_o,
  output logic               lt,
  output logic               gt,
  output logic               eq
);
  import sitsel_pkg::*;

  logic [31:0] id_r, pay_r;

  assign id    = id_r;
  assign pay_o = pay_r;
  assign lt    = valid && (id_r < key);
  assign gt    = valid && (id_r > key);
  assign eq    = valid && (id_r == key);

  // cells at or past the insert point move right, past the delete point move left
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      if (left_lt) begin
        id_r  <= key;
        pay_r <= pay;
      end else begin
        id_r  <= left_id;
        pay_r <= left_pay;
      end
    end else if (ctrl.del && !lt) begin
      id_r  <= right_id;
      pay_r <= right_pay;
    end
  end

endmodule

// ===== sv/sitsel_chain.sv =====
`timescale 1ns / 1ps
module sitsel_chain (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sitsel_pkg::ctrl_t           ctrl,
  input  logic [31:0]                 key,
  input  logic [31:0]                 pay,
  input  logic [sitsel_pkg::IDX_W-1:0] idx,
  output logic [sitsel_pkg::CNT_W-1:0] count,
  output logic                        hit,
  output logic [31:0]                 rd_id,
  output logic [31:0]                 rd_pay
);
  import sitsel_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0] ids [TABLE_DEPTH];
  logic [31:0] pays [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_v, gt_v, eq_v, pick;
  logic any_gt;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic        l_lt;
    logic [31:0] l_id, l_pay, r_id, r_pay;
    if (i == 0) begin : g_first
      assign l_lt  = 1'b1;
      assign l_id  = key;
      assign l_pay = pay;
    end else begin : g_mid
      assign l_lt  = lt_v[i-1];
      assign l_id  = ids[i-1];
      assign l_pay = pays[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign r_id  = ids[i];
      assign r_pay = pays[i];
    end else begin : g_inner
      assign r_id  = ids[i+1];
      assign r_pay = pays[i+1];
    end
    sitsel_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .key      (key),
      .pay      (pay),
      .valid    (CNT_W'(i) < count_r),
      .left_lt  (l_lt),
      .left_id  (l_id),
      .left_pay (l_pay),
      .right_id (r_id),
      .right_pay(r_pay),
      .id       (ids[i]),
      .pay_o    (pays[i]),
      .lt       (lt_v[i]),
      .gt       (gt_v[i]),
      .eq       (eq_v[i])
    );
  end

  assign hit    = |eq_v;
  assign any_gt = |gt_v;
  assign count  = count_r;

  always_comb begin
    rd_id  = '0;
    rd_pay = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (ctrl.mode)
        RD_EQ:   pick[i] = eq_v[i];
        RD_NEXT: pick[i] = any_gt ? (gt_v[i] && !(i > 0 && gt_v[(i > 0) ? i-1 : 0]))
                                  : (i == 0);
        RD_IDX:  pick[i] = (idx == IDX_W'(i));
        default: pick[i] = 1'b0;
      endcase
      if (pick[i]) begin
        rd_id  = rd_id | ids[i];
        rd_pay = rd_pay | pays[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/sitsel_modu.sv =====
`timescale 1ns / 1ps
module sitsel_modu (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [31:0]                  dividend,
  input  logic [sitsel_pkg::CNT_W-1:0] divisor,
  output logic                         done,
  output logic [sitsel_pkg::CNT_W-1:0] rem
);
  import sitsel_pkg::*;

  logic             busy_r, busy_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [31:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W:0]   trial;

  assign done = busy_r && (cnt_r == 5'd31);
  assign rem  = rem_r;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[31]};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt = trial[CNT_W-1:0];
      quo_nxt = {quo_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// ===== sv/sorted_id_table_selector_core.sv =====
`timescale 1ns / 1ps
// Sorted id table selector: two ascending id tables (class 0 and class 1).
// Input channel (in_valid/in_ready) carries one transaction: action,
// table_sel, key_id, payload_in, time_value. The result channel
// (out_valid/out_ready) returns exactly one transaction per input:
// status, found_id, found_payload and entry_count.
// One transaction is worked at a time. Insert, delete, search and looping
// select load their result from the execute state; a random select first
// runs the bit-serial remainder unit (one dividend bit per cycle).
// in_ready is high only while idle; the next transaction may be taken while
// the previous result still sits in the output register.
// If the receiver stalls with a result pending, the next transaction waits
// in its execute cycle until the output register frees.
// Each table is a row of cells, one entry per cell; insert and delete shift
// the cells past the position all together, in parallel.
// Synchronous reset empties both tables (counts to zero), restores the
// capacities to 32 and options to looping, and drops any pending result.
// Configuration goes over the APB port at byte addresses 0, 4, 8, 12:
// capacity 0, capacity 1, option 0, option 1. Write only while idle.
module sorted_id_table_selector_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic        in_table_sel,
  input  logic [31:0] in_key_id,
  input  logic [31:0] in_payload_in,
  input  logic [31:0] in_time_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_id,
  output logic [31:0] out_found_payload,
  output logic [5:0]  out_entry_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sitsel_pkg::*;

  // configuration registers
  logic [CAP_W-1:0] cap0_r, cap1_r;
  logic [1:0]       opt0_r, opt1_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap0_r <= CAP_W'(32);
      cap1_r <= CAP_W'(32);
      opt0_r <= OPT_LOOP;
      opt1_r <= OPT_LOOP;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        REG_CAP0: cap0_r <= cfg_pwdata[CAP_W-1:0];
        REG_CAP1: cap1_r <= cfg_pwdata[CAP_W-1:0];
        REG_OPT0: opt0_r <= cfg_pwdata[1:0];
        REG_OPT1: opt1_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_CAP0: cfg_prdata = {{(32-CAP_W){1'b0}}, cap0_r};
      REG_CAP1: cfg_prdata = {{(32-CAP_W){1'b0}}, cap1_r};
      REG_OPT0: cfg_prdata = {30'b0, opt0_r};
      REG_OPT1: cfg_prdata = {30'b0, opt1_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // captured transaction
  state_t      state_r, state_nxt;
  logic [1:0]  act_r;
  logic        sel_r;
  logic [31:0] key_r, pay_r, tval_r;

  logic        in_acc;
  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_action;
      sel_r  <= in_table_sel;
      key_r  <= in_key_id;
      pay_r  <= in_payload_in;
      tval_r <= in_time_value;
    end
  end

  // table rows and remainder unit
  ctrl_t            ctrl0, ctrl1;
  rd_mode_t         mode;
  logic [CNT_W-1:0] cnt0, cnt1, cnt;
  logic             hit0, hit1, hit;
  logic [31:0]      rid0, rid1, rpay0, rpay1, rid, rpay;
  logic [CNT_W-1:0] rem;
  logic             div_start, div_done;
  logic             do_ins, do_del;

  sitsel_chain u_tab0 (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl0), .key(key_r), .pay(pay_r),
    .idx(rem[IDX_W-1:0]), .count(cnt0), .hit(hit0), .rd_id(rid0), .rd_pay(rpay0)
  );

  sitsel_chain u_tab1 (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl1), .key(key_r), .pay(pay_r),
    .idx(rem[IDX_W-1:0]), .count(cnt1), .hit(hit1), .rd_id(rid1), .rd_pay(rpay1)
  );

  sitsel_modu u_modu (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(tval_r),
    .divisor(cnt), .done(div_done), .rem(rem)
  );

  // addressed-table view
  logic [1:0]       opt;
  logic [CAP_W-1:0] cap;
  logic             full;

  assign cnt  = sel_r ? cnt1 : cnt0;
  assign hit  = sel_r ? hit1 : hit0;
  assign rid  = sel_r ? rid1 : rid0;
  assign rpay = sel_r ? rpay1 : rpay0;
  assign opt  = sel_r ? opt1_r : opt0_r;
  assign cap  = sel_r ? cap1_r : cap0_r;
  // effective capacity is the register capped at the row length
  assign full = (CMP_W'(cnt) >= CMP_W'(cap)) || (cnt == CNT_W'(TABLE_DEPTH));

  always_comb begin
    case (act_r)
      ACT_SEARCH: mode = RD_EQ;
      ACT_SELECT: mode = (opt == OPT_RANDOM) ? RD_IDX : RD_NEXT;
      default:    mode = RD_EQ;
    endcase
  end

  // output register
  logic             out_valid_r;
  logic [2:0]       status_r, status_c;
  logic [31:0]      fid_r, fid_c, fpay_r, fpay_c;
  logic [CNT_W-1:0] ecnt_r, ecnt_c;
  logic             out_free, out_load;

  assign out_free = !out_valid_r || out_ready;

  // result of the current transaction against the addressed table
  always_comb begin
    status_c = ST_MISS;
    fid_c    = '0;
    fpay_c   = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    case (act_r)
      ACT_INSERT: begin
        if (key_r == '0) begin
          status_c = ST_ZERO;
        end else if (full) begin
          status_c = ST_FULL;
        end else if (hit) begin
          status_c = ST_DUP;
        end else begin
          status_c = ST_OK;
          do_ins   = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (key_r != '0 && hit) begin
          status_c = ST_OK;
          do_del   = 1'b1;
        end
      end
      ACT_SEARCH: begin
        if (key_r != '0 && hit) begin
          status_c = ST_OK;
          fid_c    = rid;
          fpay_c   = rpay;
        end
      end
      ACT_SELECT: begin
        if (opt == OPT_LOOP || opt == OPT_RANDOM) begin
          if (cnt != '0) begin
            status_c = ST_OK;
            fid_c    = rid;
            fpay_c   = rpay;
          end
        end else begin
          status_c = ST_NOPOL;
        end
      end
      default: ;
    endcase
    ecnt_c = cnt;
    if (do_ins) begin
      ecnt_c = cnt + CNT_W'(1);
    end else if (do_del) begin
      ecnt_c = cnt - CNT_W'(1);
    end
  end

  // marks that the remainder for this transaction is already in place
  logic u_modu_busy_seen_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (act_r == ACT_SELECT && opt == OPT_RANDOM && cnt != '0 && mode == RD_IDX
            && !div_done && !u_modu_busy_seen_r) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_modu_busy_seen_r <= 1'b0;
    end else if (div_done) begin
      u_modu_busy_seen_r <= 1'b1;
    end else if (in_acc) begin
      u_modu_busy_seen_r <= 1'b0;
    end
  end

  assign ctrl0 = '{ins: out_load && do_ins && !sel_r, del: out_load && do_del && !sel_r,
                   mode: mode};
  assign ctrl1 = '{ins: out_load && do_ins && sel_r, del: out_load && do_del && sel_r,
                   mode: mode};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= status_c;
      fid_r    <= fid_c;
      fpay_r   <= fpay_c;
      ecnt_r   <= ecnt_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found_id      = fid_r;
  assign out_found_payload = fpay_r;
  assign out_entry_count   = 6'(ecnt_r);

endmodule
